/* design/assert_macros.svh */
// Assertion helpers for the design files. They sample on clk and are
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, pre, post)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/lppa_pkg.sv */
package lppa_pkg;

	localparam int CMD_W      = 2;
	localparam int COORD_W    = 16;
	localparam int REFL_W     = 9;
	localparam int MAXY_W     = 15;
	localparam int CNT_W      = 5;
	localparam int SLOT_W     = 4;
	localparam int DIM_W      = 15;
	localparam int COEF_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_BOXES  = 16;
	localparam int BOX_IDX_W  = 4;
	localparam int MAT_N      = 12;
	localparam int MAT_COLS   = 4;

	// Arithmetic widths: coefficient times coordinate, then a sum of four terms.
	localparam int PROD_W  = COEF_W + COORD_W;
	localparam int CONST_W = COEF_W + 8;
	localparam int ACC_W   = PROD_W + 2;
	localparam int Q_W     = 16;
	localparam int DW      = ACC_W + Q_W;
	localparam int HB_W    = COORD_W + 2;

	localparam logic signed [COORD_W-1:0] PIX_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] PIX_MIN = 16'sh8000;

	localparam logic [CMD_W-1:0] CMD_POINT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BOX   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COEF  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_REFLECT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_COUNT   = 3'd6;

	// Pipeline stage numbers.
	localparam int ST_PROD = 1;
	localparam int ST_SUM  = 2;
	localparam int ST_DIV0 = 3;
	localparam int ST_SAT  = ST_DIV0 + Q_W + 1;
	localparam int ST_HIT  = ST_SAT + 1;
	localparam int ST_OUT  = ST_HIT + 1;
	localparam int NST     = ST_OUT;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [REFL_W-1:0]         r;
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [DIM_W-1:0]          wdt;
		logic [DIM_W-1:0]          hgt;
	} meta_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [DIM_W-1:0]          wdt;
		logic [DIM_W-1:0]          hgt;
	} box_t;

	typedef struct packed {
		logic [DW-1:0]    rem_u;
		logic [DW-1:0]    rem_v;
		logic [Q_W-1:0]   q_u;
		logic [Q_W-1:0]   q_v;
		logic [ACC_W-1:0] dmag;
		logic             neg_u;
		logic             neg_v;
		logic             ovf_u;
		logic             ovf_v;
		logic             dz;
	} div_t;

endpackage

/* design/lppa_if.sv */
interface lppa_pt_if import lppa_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [REFL_W-1:0]         reflect;
	logic [SLOT_W-1:0]         slot;
	logic signed [COORD_W-1:0] box_left;
	logic signed [COORD_W-1:0] box_top;
	logic [DIM_W-1:0]          box_width;
	logic [DIM_W-1:0]          box_height;
	logic signed [COEF_W-1:0]  coef;

	modport source (output valid, cmd, pos_x, pos_y, pos_z, reflect, slot, box_left,
		box_top, box_width, box_height, coef, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, pos_z, reflect, slot, box_left,
		box_top, box_width, box_height, coef, output ready);
endinterface

interface lppa_res_if import lppa_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic [REFL_W-1:0]         out_reflect;
	logic signed [COORD_W-1:0] pixel_u;
	logic signed [COORD_W-1:0] pixel_v;
	logic [BOX_IDX_W-1:0]      box_index;
	logic                      assigned;

	modport source (output valid, out_x, out_y, out_z, out_reflect, pixel_u, pixel_v,
		box_index, assigned, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_reflect, pixel_u, pixel_v,
		box_index, assigned, output ready);
endinterface

interface lppa_cfg_if import lppa_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/lidar_point_project_assign_core.sv */
// Channel  Role   Word
// cfg      sink   register index and write data
// pt       sink   point, box load or coefficient load
// res      source kept point with its pixel and box assignment
//
// One word enters per cycle unless a stall on res holds it.
// The pipeline holds a 16-stage restoring divider, one quotient bit a stage.
// Box loads travel the pipeline and update the box table at the saturation stage,
// so they stay ordered with points. Coefficient loads take effect on acceptance.
// A stall on res freezes the whole pipeline; arst_n clears the valid bits and
// the configuration registers, not the matrix or the box table.
`include "assert_macros.svh"

module lidar_point_project_assign_core import lppa_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	lppa_cfg_if.sink    cfg,
	lppa_pt_if.sink     pt,
	lppa_res_if.source  res
);

	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_z_q, max_z_q;
	logic [MAXY_W-1:0]         max_y_q;
	logic [REFL_W-1:0]         min_reflect_q;
	logic [CNT_W-1:0]          box_count_q;

	logic signed [COEF_W-1:0]  mat_q [MAT_N];
	box_t                      box_q [MAX_BOXES];

	logic  adv, acc_in, keep;
	logic  pt_v_s [1:NST];
	logic  bw_v_s [1:ST_SAT];
	meta_t meta_s [1:NST];

	logic signed [PROD_W-1:0]  prod_s1 [3][3];
	logic signed [CONST_W-1:0] cst_s1 [3];
	logic signed [ACC_W-1:0]   acc_s2 [3];
	div_t                      dv_s [0:Q_W];
	div_t                      dv_nx [1:Q_W];

	logic signed [COORD_W-1:0] pix_u_s20, pix_v_s20, pix_u_s21, pix_v_s21;
	logic                      dz_s20;
	logic [MAX_BOXES-1:0]      hit_nx, hit_s21;
	logic signed [COORD_W-1:0] pix_u_s22, pix_v_s22;
	logic [BOX_IDX_W-1:0]      idx_s22, idx_nx;
	logic                      asg_s22, asg_nx;

	logic [COORD_W:0] ay;
	logic [CNT_W-1:0] n_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q       <= 16'sd512;
			max_x_q       <= 16'sd5120;
			max_y_q       <= 15'd512;
			min_z_q       <= -16'sd384;
			max_z_q       <= -16'sd230;
			min_reflect_q <= 9'd26;
			box_count_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MIN_X:       min_x_q       <= cfg.data;
				CFG_MAX_X:       max_x_q       <= cfg.data;
				CFG_MAX_Y:       max_y_q       <= cfg.data[MAXY_W-1:0];
				CFG_MIN_Z:       min_z_q       <= cfg.data;
				CFG_MAX_Z:       max_z_q       <= cfg.data;
				CFG_MIN_REFLECT: min_reflect_q <= cfg.data[REFL_W-1:0];
				CFG_BOX_COUNT:   box_count_q   <= cfg.data[CNT_W-1:0];
				default:         ;
			endcase
		end
	end

	// The whole pipeline moves together whenever the output word can advance.
	assign adv      = !pt_v_s[NST] || res.ready;
	assign pt.ready = adv;
	assign acc_in   = pt.valid && adv;

	always_comb begin
		ay = pt.pos_y[COORD_W-1] ? (COORD_W+1)'(0) - (COORD_W+1)'(pt.pos_y)
			: (COORD_W+1)'(pt.pos_y);
		keep = (pt.pos_x >= min_x_q) && (pt.pos_x <= max_x_q)
			&& (pt.pos_z >= min_z_q) && (pt.pos_z <= max_z_q)
			&& (pt.pos_z[COORD_W-1] || pt.pos_z == '0)
			&& (ay <= (COORD_W+1)'(max_y_q)) && (pt.reflect >= min_reflect_q);
	end

	always_ff @(posedge clk) begin
		if (acc_in && pt.cmd == CMD_COEF && pt.slot < SLOT_W'(MAT_N))
			mat_q[pt.slot] <= pt.coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) pt_v_s[i] <= 1'b0;
			for (int i = 1; i <= ST_SAT; i++) bw_v_s[i] <= 1'b0;
		end else if (adv) begin
			pt_v_s[1] <= pt.valid && pt.cmd == CMD_POINT && keep;
			bw_v_s[1] <= pt.valid && pt.cmd == CMD_BOX;
			for (int i = 2; i <= NST; i++) pt_v_s[i] <= pt_v_s[i-1];
			for (int i = 2; i <= ST_SAT; i++) bw_v_s[i] <= bw_v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[1] <= '{x: pt.pos_x, y: pt.pos_y, z: pt.pos_z, r: pt.reflect,
				slot: pt.slot, left: pt.box_left, top: pt.box_top,
				wdt: pt.box_width, hgt: pt.box_height};
			for (int i = 2; i <= NST; i++) meta_s[i] <= meta_s[i-1];
		end
	end

	// Stage 1: one multiplier per matrix entry, the fourth column is a shift.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k][0] <= PROD_W'(mat_q[k*MAT_COLS])   * PROD_W'(pt.pos_x);
				prod_s1[k][1] <= PROD_W'(mat_q[k*MAT_COLS+1]) * PROD_W'(pt.pos_y);
				prod_s1[k][2] <= PROD_W'(mat_q[k*MAT_COLS+2]) * PROD_W'(pt.pos_z);
				cst_s1[k]     <= {mat_q[k*MAT_COLS+3], 8'b0};
			end
		end
	end

	// Stage 2: row sums.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				acc_s2[k] <= ACC_W'(prod_s1[k][0]) + ACC_W'(prod_s1[k][1])
					+ ACC_W'(prod_s1[k][2]) + ACC_W'(cst_s1[k]);
		end
	end

	// Stage 3: magnitudes and signs. A quotient of 2^16 or more saturates, so
	// the divider only has to produce 16 magnitude bits.
	always_ff @(posedge clk) begin
		logic [ACC_W-1:0] nu, nv, dm;
		nu = acc_s2[0][ACC_W-1] ? ACC_W'(0) - acc_s2[0] : acc_s2[0];
		nv = acc_s2[1][ACC_W-1] ? ACC_W'(0) - acc_s2[1] : acc_s2[1];
		dm = acc_s2[2][ACC_W-1] ? ACC_W'(0) - acc_s2[2] : acc_s2[2];
		if (adv) begin
			dv_s[0].rem_u <= DW'(nu);
			dv_s[0].rem_v <= DW'(nv);
			dv_s[0].q_u   <= '0;
			dv_s[0].q_v   <= '0;
			dv_s[0].dmag  <= dm;
			dv_s[0].neg_u <= acc_s2[0][ACC_W-1] ^ acc_s2[2][ACC_W-1];
			dv_s[0].neg_v <= acc_s2[1][ACC_W-1] ^ acc_s2[2][ACC_W-1];
			dv_s[0].ovf_u <= DW'(nu) >= (DW'(dm) << Q_W);
			dv_s[0].ovf_v <= DW'(nv) >= (DW'(dm) << Q_W);
			dv_s[0].dz    <= acc_s2[2] == '0;
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	always_comb begin
		logic [DW-1:0] dsh;
		for (int s = 1; s <= Q_W; s++) begin
			dsh = DW'(dv_s[s-1].dmag) << (Q_W - s);
			dv_nx[s] = dv_s[s-1];
			if (dv_s[s-1].rem_u >= dsh) begin
				dv_nx[s].rem_u = dv_s[s-1].rem_u - dsh;
				dv_nx[s].q_u[Q_W-s] = 1'b1;
			end
			if (dv_s[s-1].rem_v >= dsh) begin
				dv_nx[s].rem_v = dv_s[s-1].rem_v - dsh;
				dv_nx[s].q_v[Q_W-s] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 1; s <= Q_W; s++) dv_s[s] <= dv_nx[s];
		end
	end

	function automatic logic signed [COORD_W-1:0] sat_pix(logic [Q_W-1:0] q,
		logic neg, logic ovf, logic dz);
		logic [Q_W:0] mag;
		mag = {1'b0, q};
		if (dz)
			sat_pix = '0;
		else if (ovf)
			sat_pix = neg ? PIX_MIN : PIX_MAX;
		else if (!neg)
			sat_pix = (mag > (Q_W+1)'(PIX_MAX)) ? PIX_MAX : q;
		else
			sat_pix = (mag > ((Q_W+1)'(1) << (Q_W-1))) ? PIX_MIN
				: COORD_W'((Q_W+1)'(0) - mag);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_u_s20 <= sat_pix(dv_s[Q_W].q_u, dv_s[Q_W].neg_u, dv_s[Q_W].ovf_u, dv_s[Q_W].dz);
			pix_v_s20 <= sat_pix(dv_s[Q_W].q_v, dv_s[Q_W].neg_v, dv_s[Q_W].ovf_v, dv_s[Q_W].dz);
			dz_s20    <= dv_s[Q_W].dz;
		end
	end

	// A box load lands here, behind every point that was accepted before it.
	always_ff @(posedge clk) begin
		if (adv && bw_v_s[ST_SAT])
			box_q[meta_s[ST_SAT].slot] <= '{left: meta_s[ST_SAT].left,
				top: meta_s[ST_SAT].top, wdt: meta_s[ST_SAT].wdt, hgt: meta_s[ST_SAT].hgt};
	end

	assign n_eff = (box_count_q > CNT_W'(MAX_BOXES)) ? CNT_W'(MAX_BOXES) : box_count_q;

	// Box extents are compared as signed values, so the width and height are
	// extended as non-negative signed numbers.
	always_comb begin
		for (int i = 0; i < MAX_BOXES; i++) begin
			hit_nx[i] = !dz_s20 && (CNT_W'(i) < n_eff)
				&& (HB_W'(pix_u_s20) >= HB_W'(box_q[i].left))
				&& (HB_W'(pix_u_s20) < HB_W'(box_q[i].left)
					+ HB_W'($signed({1'b0, box_q[i].wdt})))
				&& (HB_W'(pix_v_s20) >= HB_W'(box_q[i].top))
				&& (HB_W'(pix_v_s20) < HB_W'(box_q[i].top)
					+ HB_W'($signed({1'b0, box_q[i].hgt})));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s21   <= hit_nx;
			pix_u_s21 <= pix_u_s20;
			pix_v_s21 <= pix_v_s20;
		end
	end

	// Exactly one enclosing box: the index bits can simply be ORed together.
	always_comb begin
		idx_nx = '0;
		asg_nx = (hit_s21 != '0) && ((hit_s21 & (hit_s21 - MAX_BOXES'(1))) == '0);
		for (int i = 0; i < MAX_BOXES; i++) begin
			if (hit_s21[i]) idx_nx = idx_nx | BOX_IDX_W'(i);
		end
		if (!asg_nx) idx_nx = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_u_s22 <= pix_u_s21;
			pix_v_s22 <= pix_v_s21;
			idx_s22   <= idx_nx;
			asg_s22   <= asg_nx;
		end
	end

	assign res.valid       = pt_v_s[NST];
	assign res.out_x       = meta_s[NST].x;
	assign res.out_y       = meta_s[NST].y;
	assign res.out_z       = meta_s[NST].z;
	assign res.out_reflect = meta_s[NST].r;
	assign res.pixel_u     = pix_u_s22;
	assign res.pixel_v     = pix_v_s22;
	assign res.box_index   = idx_s22;
	assign res.assigned    = asg_s22;

	`ASSERT_IMPLY(a_idx_in_use, res.valid && res.assigned, CNT_W'(res.box_index) < box_count_q)
	`ASSERT_IMPLY(a_unassigned_zero, res.valid && !res.assigned, res.box_index == '0)
	`ASSERT_IMPLY(a_kept_in_limits, res.valid, (res.out_z <= max_z_q) && (res.out_x >= min_x_q))
	`ASSERT_NEXT(a_stall_holds, res.valid && !res.ready, res.valid)

endmodule
